FILE: design/qbss_pkg.sv
// Package for the queue buffer-state set / extract block.
// Holds sizing constants, command and register codes, and the word structs.
// No dependencies.
package qbss_pkg;

  localparam int MAX_QUEUES   = 64;
  localparam int RING_ENTRIES = 128;
  localparam int IDX_W        = $clog2(RING_ENTRIES);
  localparam int QSEL_W       = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int ADDR_W       = QSEL_W + IDX_W;
  localparam int STORE_DEPTH  = MAX_QUEUES * RING_ENTRIES;
  localparam int TOT_W        = 9;
  localparam int CNT_W        = IDX_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [TOT_W-1:0] MAX_QUEUES_C  = TOT_W'(MAX_QUEUES);
  localparam logic [CNT_W-1:0] RING_ENTRIES_C = CNT_W'(RING_ENTRIES);

  localparam logic [7:0] COMPLETED_RESET = 8'd130;
  localparam logic [7:0] ACKED_RESET     = 8'd129;

  typedef enum logic {
    CMD_SET     = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CC_DONE      = 2'd0,
    CC_STOPPED   = 2'd1,
    CC_NOT_READY = 2'd2
  } cc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_QUEUES  = 3'd0,
    CFG_OUTPUT_QUEUES = 3'd1,
    CFG_DEVICE_READY  = 3'd2,
    CFG_COMPLETED     = 3'd3,
    CFG_ACKED         = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  queue_index;
    logic [7:0]  buffer_index;
    logic [31:0] buffer_count;
    logic [7:0]  new_state;
    logic        auto_ack;
  } in_word_t;

  typedef struct packed {
    logic [6:0] next_index;
    logic [7:0] remaining_count;
    logic [7:0] extracted_state;
    logic [1:0] cond_code;
    logic       spec_exception;
  } out_word_t;

endpackage

FILE: design/queue_buffer_state_set_extract.sv
// Queue buffer-state set / extract: one request word in, one result word out.
// Steps per word: one read-compare-write per entry walked, then a stop check, then the
//   output load, which waits while a stalled result is held; a skipped walk goes to it at once.
// One word at a time: the next is taken only after the last result is loaded for output.
// Reset (rst_n, synchronous): a clearing pass zeroes all 8192 entries of the state store.
// Depends on qbss_pkg.
module queue_buffer_state_set_extract
  import qbss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // One-hot sequencer: clear the store, wait for a word, walk the ring, post.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [5:0] in_queues_r;
  logic [5:0] out_queues_r;
  logic       dev_ready_r;
  logic [7:0] completed_r;
  logic [7:0] acked_r;

  // Clearing pass address
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Request context held through the walk
  logic [QSEL_W-1:0] q_r, q_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              cmd_r, cmd_nxt;
  logic [7:0]        nst_r, nst_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        first_r, first_nxt;
  logic              first_cyc_r, first_cyc_nxt;
  logic [1:0]        cc_r, cc_nxt;
  logic              spec_r, spec_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  // State store: one write port, one registered read port
  logic [7:0]        store_mem [STORE_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              in_accept;
  logic [CNT_W-1:0]  clamped_cnt;
  logic [TOT_W-1:0]  total_raw;
  logic [TOT_W-1:0]  total_q;
  logic              q_bad;
  logic              idx_bad;
  logic [7:0]        first_val;
  logic              walk_stop;
  logic [IDX_W-1:0]  idx_inc;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the requested count to one full ring.
  assign clamped_cnt = (in_data.buffer_count >= 32'(RING_ENTRIES)) ? RING_ENTRIES_C
                                                                   : in_data.buffer_count[CNT_W-1:0];

  // Established queues, capped at the store size.
  assign total_raw = TOT_W'(in_queues_r) + TOT_W'(out_queues_r);
  assign total_q   = (total_raw > MAX_QUEUES_C) ? MAX_QUEUES_C : total_raw;
  assign q_bad     = (TOT_W'(in_data.queue_index) >= total_q);
  assign idx_bad   = (in_data.buffer_index > 8'(RING_ENTRIES - 1));

  // The first walk cycle sees the first entry itself; later ones compare to it.
  assign first_val = first_cyc_r ? rd_data_r : first_r;
  assign walk_stop = (count_r == '0) || (rd_data_r != first_val);
  assign idx_inc   = idx_r + IDX_W'(1);

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_queues_r  <= '0;
      out_queues_r <= '0;
      dev_ready_r  <= 1'b0;
      completed_r  <= COMPLETED_RESET;
      acked_r      <= ACKED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_QUEUES:  in_queues_r  <= cfg_wdata[5:0];
        CFG_OUTPUT_QUEUES: out_queues_r <= cfg_wdata[5:0];
        CFG_DEVICE_READY:  dev_ready_r  <= cfg_wdata[0];
        CFG_COMPLETED:     completed_r  <= cfg_wdata;
        CFG_ACKED:         acked_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    nst_nxt       = nst_r;
    ack_nxt       = ack_r;
    first_nxt     = first_r;
    first_cyc_nxt = 1'b0;
    cc_nxt        = cc_r;
    spec_nxt      = spec_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = {q_r, idx_r};
    mem_wdata     = (cmd_r == CMD_SET) ? nst_r : acked_r;
    // Walk reads one entry ahead of the one being written.
    mem_raddr     = {q_r, idx_inc};

    // Drop the posted word once taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = {in_data.queue_index[QSEL_W-1:0], in_data.buffer_index[IDX_W-1:0]};
        if (in_accept) begin
          q_nxt     = in_data.queue_index[QSEL_W-1:0];
          idx_nxt   = in_data.buffer_index[IDX_W-1:0];
          count_nxt = clamped_cnt;
          cmd_nxt   = in_data.cmd;
          nst_nxt   = in_data.new_state;
          ack_nxt   = in_data.auto_ack;
          first_nxt = '0;
          cc_nxt    = CC_DONE;
          spec_nxt  = 1'b0;
          if (!dev_ready_r) begin
            cc_nxt    = CC_NOT_READY;
            state_nxt = S_OUT;
          end else if (q_bad || idx_bad) begin
            spec_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            first_cyc_nxt = 1'b1;
            state_nxt     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (first_cyc_r) begin
          first_nxt = rd_data_r;
        end
        if (walk_stop) begin
          cc_nxt    = (count_r != '0) ? CC_STOPPED : CC_DONE;
          state_nxt = S_OUT;
        end else begin
          // Rewrite the current entry and advance to the next one.
          mem_we    = (cmd_r == CMD_SET) || (ack_r && (rd_data_r == completed_r));
          idx_nxt   = idx_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_OUT: begin
        // Load the result once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.next_index      = idx_r;
          out_data_nxt.remaining_count = 8'(count_r);
          out_data_nxt.extracted_state = (cmd_r == CMD_EXTRACT) ? first_r : 8'h00;
          out_data_nxt.cond_code       = cc_r;
          out_data_nxt.spec_exception  = spec_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      first_cyc_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      first_cyc_r <= first_cyc_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    nst_r      <= nst_nxt;
    ack_r      <= ack_nxt;
    first_r    <= first_nxt;
    cc_r       <= cc_nxt;
    spec_r     <= spec_nxt;
    out_data_r <= out_data_nxt;
  end

  // State store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem[mem_raddr];
  end

  // The store is touched only by the clearing pass or a walk.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !mem_we)
    else $error("state store written outside clear or walk");

  // The remaining count never exceeds one ring.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (count_r <= RING_ENTRIES_C))
    else $error("remaining count above ring size");

  // A word taken while the device is not ready skips the walk.
  a_not_ready_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !dev_ready_r) |=> (state_r == S_OUT))
    else $error("not-ready word entered the walk");

  // A held result blocks the next one from overwriting it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result posted over a stalled word");

endmodule
